FILE: rtl/core/dual_priority_job_queue_macros.svh
// Assertion macros shared by the job queue RTL.
`ifndef DUAL_PRIORITY_JOB_QUEUE_MACROS_SVH
`define DUAL_PRIORITY_JOB_QUEUE_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define DPJQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define DPJQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dpjq_pkg.sv
// Types, constants and ring helpers for the dual priority job queue.
package dpjq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CAP_W = PTR_W + 1;
	localparam int PEND_W = 16;
	localparam logic [PEND_W-1:0] OUTSTANDING_MAX = 16'hFFFF;
	localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
	localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(QUEUE_DEPTH);

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CAP_W-1:0] cap_t;

	typedef enum logic [1:0] {
		MODE_SUBMIT = 2'd0,
		MODE_FETCH  = 2'd1,
		MODE_PRIO   = 2'd2,
		MODE_FINISH = 2'd3
	} mode_e;

	typedef enum logic [2:0] {
		STAT_QUEUED    = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_GIVEN     = 3'd2,
		STAT_NONE      = 3'd3,
		STAT_REORDERED = 3'd4,
		STAT_FINISHED  = 3'd5
	} status_e;

	typedef enum logic {
		CFG_IMM_CAP = 1'b0,
		CFG_STD_CAP = 1'b1
	} cfg_idx_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH_WAIT,
		S_SCAN,
		S_CMP,
		S_SWAP_A,
		S_SWAP_B,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        queue_select;
		logic [31:0] job_type;
		logic [63:0] job_handle;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] out_handle;
		logic [31:0] out_type;
		logic        from_queue;
		logic [5:0]  immediate_count;
		logic [5:0]  standard_count;
		logic [15:0] outstanding;
		logic        all_done;
	} out_item_t;

	typedef struct packed {
		logic [31:0] etype;
		logic [63:0] handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic ptr_t ring_next(ptr_t p, cap_t cap);
		cap_t n;
		n = {1'b0, p} + CAP_W'(1);
		return (n == cap) ? '0 : n[PTR_W-1:0];
	endfunction

	function automatic ptr_t ring_count(ptr_t head, ptr_t tail, cap_t cap);
		cap_t c;
		if (head >= tail) begin
			c = {1'b0, head} - {1'b0, tail};
		end else begin
			c = {1'b0, head} + cap - {1'b0, tail};
		end
		return c[PTR_W-1:0];
	endfunction

	function automatic cap_t clamp_cap(cap_t v);
		if (v < CAP_MIN) begin
			return CAP_MIN;
		end
		if (v > CAP_MAX) begin
			return CAP_MAX;
		end
		return v;
	endfunction

endpackage

FILE: rtl/core/dpjq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dpjq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/dual_priority_job_queue.sv
// Dual priority job queue: two ring queues in RAM under one sequencer.
// Sequence: submit, finish and empty fetch go from execute straight to done; fetch of a job
// passes through a wait state for the registered RAM read; prioritize scans both queues and swaps matches forward.
// Only one transaction is in flight: the next is accepted once the sequencer is back in idle
// after its result registers; a stalled earlier result holds the last state.
// Reset (async, arst_n low): pointers and counter zero, capacities 64; RAM not cleared.
module dual_priority_job_queue
	import dpjq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [6:0] cfg_data
);

	state_t state_q, state_d;

	ptr_t imm_head_q, imm_tail_q, std_head_q, std_tail_q;
	cap_t imm_cap_q, std_cap_q;
	logic [PEND_W-1:0] pending_q;
	logic out_valid_q;
	out_item_t out_data_q;

	logic [1:0]  mode_q;
	logic        sel_q;
	logic [31:0] type_q;
	logic [63:0] handle_q;
	logic        qsel_q;
	ptr_t        scan_q, front_q;
	entry_t      hold_q;
	status_e     status_q;
	logic [63:0] res_handle_q;
	logic [31:0] res_type_q;
	logic        res_from_q;

	logic   [1:0] ram_we, ram_re;
	ptr_t   ram_waddr, ram_raddr;
	entry_t ram_wdata;
	entry_t imm_rdata, std_rdata, rd_sel;

	logic imm_empty, std_empty, sub_full, at_end, type_match, out_free, in_acc;
	ptr_t head_sel, tail_sel, scan_next, front_next;
	cap_t cap_sel, sub_cap;
	ptr_t sub_head, sub_tail;
	ptr_t imm_cnt, std_cnt;

	assign in_acc     = in_valid && in_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_free   = !out_valid_q || out_ready;

	assign imm_empty  = (imm_head_q == imm_tail_q);
	assign std_empty  = (std_head_q == std_tail_q);
	assign head_sel   = qsel_q ? std_head_q : imm_head_q;
	assign tail_sel   = qsel_q ? std_tail_q : imm_tail_q;
	assign cap_sel    = qsel_q ? std_cap_q : imm_cap_q;
	assign rd_sel     = qsel_q ? std_rdata : imm_rdata;
	assign sub_head   = sel_q ? std_head_q : imm_head_q;
	assign sub_tail   = sel_q ? std_tail_q : imm_tail_q;
	assign sub_cap    = sel_q ? std_cap_q : imm_cap_q;
	assign sub_full   = (ring_next(sub_head, sub_cap) == sub_tail);
	assign at_end     = (scan_q == head_sel);
	assign type_match = (rd_sel.etype == type_q);
	assign scan_next  = ring_next(scan_q, cap_sel);
	assign front_next = ring_next(front_q, cap_sel);
	assign imm_cnt    = ring_count(imm_head_q, imm_tail_q, imm_cap_q);
	assign std_cnt    = ring_count(std_head_q, std_tail_q, std_cap_q);

	dpjq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_imm_ram (
		.clk   (clk),
		.we    (ram_we[0]),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re[0]),
		.raddr (ram_raddr),
		.rdata (imm_rdata)
	);

	dpjq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_std_ram (
		.clk   (clk),
		.we    (ram_we[1]),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re[1]),
		.raddr (ram_raddr),
		.rdata (std_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (mode_q)
					MODE_FETCH: state_d = (imm_empty && std_empty) ? S_DONE : S_FETCH_WAIT;
					MODE_PRIO:  state_d = S_SCAN;
					default:    state_d = S_DONE;
				endcase
			end
			S_FETCH_WAIT: state_d = S_DONE;
			S_SCAN: begin
				if (!at_end) begin
					state_d = S_CMP;
				end else if (qsel_q) begin
					state_d = S_DONE;
				end
			end
			S_CMP:    state_d = (type_match && front_q != scan_q) ? S_SWAP_A : S_SCAN;
			S_SWAP_A: state_d = S_SWAP_B;
			S_SWAP_B: state_d = S_SCAN;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = '0;
		ram_re    = '0;
		ram_waddr = scan_q;
		ram_raddr = scan_q;
		ram_wdata = hold_q;
		case (state_q)
			S_EXEC: begin
				if (mode_q == MODE_SUBMIT && !sub_full) begin
					ram_we[sel_q] = 1'b1;
					ram_waddr     = sub_head;
					ram_wdata     = '{etype: type_q, handle: handle_q};
				end else if (mode_q == MODE_FETCH) begin
					if (!imm_empty) begin
						ram_re[0] = 1'b1;
						ram_raddr = imm_tail_q;
					end else if (!std_empty) begin
						ram_re[1] = 1'b1;
						ram_raddr = std_tail_q;
					end
				end
			end
			S_SCAN: begin
				if (!at_end) begin
					ram_re[qsel_q] = 1'b1;
				end
			end
			S_CMP: begin
				if (type_match && front_q != scan_q) begin
					ram_re[qsel_q] = 1'b1;
					ram_raddr      = front_q;
				end
			end
			S_SWAP_A: begin
				ram_we[qsel_q] = 1'b1;
				ram_wdata      = rd_sel;
			end
			S_SWAP_B: begin
				ram_we[qsel_q] = 1'b1;
				ram_waddr      = front_q;
			end
			default: begin
				ram_we = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			imm_head_q  <= '0;
			imm_tail_q  <= '0;
			std_head_q  <= '0;
			std_tail_q  <= '0;
			imm_cap_q   <= CAP_MAX;
			std_cap_q   <= CAP_MAX;
			pending_q   <= '0;
			out_valid_q <= 1'b0;
			qsel_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_EXEC: begin
					case (mode_q)
						MODE_SUBMIT: begin
							if (!sub_full) begin
								if (sel_q) begin
									std_head_q <= ring_next(std_head_q, std_cap_q);
								end else begin
									imm_head_q <= ring_next(imm_head_q, imm_cap_q);
								end
							end
							if (pending_q != OUTSTANDING_MAX) begin
								pending_q <= pending_q + PEND_W'(1);
							end
						end
						MODE_FETCH:  qsel_q <= imm_empty;
						MODE_PRIO:   qsel_q <= 1'b0;
						default: begin
							if (pending_q != '0) begin
								pending_q <= pending_q - PEND_W'(1);
							end
						end
					endcase
				end
				S_FETCH_WAIT: begin
					if (qsel_q) begin
						std_tail_q <= ring_next(std_tail_q, std_cap_q);
					end else begin
						imm_tail_q <= ring_next(imm_tail_q, imm_cap_q);
					end
				end
				S_SCAN: begin
					if (at_end && !qsel_q) begin
						qsel_q <= 1'b1;
					end
				end
				default: begin
					qsel_q <= qsel_q;
				end
			endcase
			if (cfg_we) begin
				if (cfg_index == CFG_IMM_CAP) begin
					imm_cap_q  <= clamp_cap(cfg_data);
					imm_head_q <= '0;
					imm_tail_q <= '0;
				end else begin
					std_cap_q  <= clamp_cap(cfg_data);
					std_head_q <= '0;
					std_tail_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q       <= in_data.mode;
			sel_q        <= in_data.queue_select;
			type_q       <= in_data.job_type;
			handle_q     <= in_data.job_handle;
			res_handle_q <= '0;
			res_type_q   <= '0;
			res_from_q   <= 1'b0;
		end
		case (state_q)
			S_EXEC: begin
				case (mode_q)
					MODE_SUBMIT: status_q <= sub_full ? STAT_FULL : STAT_QUEUED;
					MODE_FETCH:  status_q <= STAT_NONE;
					MODE_PRIO: begin
						status_q <= STAT_REORDERED;
						scan_q   <= imm_tail_q;
						front_q  <= imm_tail_q;
					end
					default:     status_q <= STAT_FINISHED;
				endcase
			end
			S_FETCH_WAIT: begin
				status_q     <= STAT_GIVEN;
				res_handle_q <= rd_sel.handle;
				res_type_q   <= rd_sel.etype;
				res_from_q   <= qsel_q;
			end
			S_SCAN: begin
				if (at_end && !qsel_q) begin
					scan_q  <= std_tail_q;
					front_q <= std_tail_q;
				end
			end
			S_CMP: begin
				hold_q <= rd_sel;
				if (!type_match) begin
					scan_q <= scan_next;
				end else if (front_q == scan_q) begin
					scan_q  <= scan_next;
					front_q <= front_next;
				end
			end
			S_SWAP_B: begin
				scan_q  <= scan_next;
				front_q <= front_next;
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q.status          <= status_q;
					out_data_q.out_handle      <= res_handle_q;
					out_data_q.out_type        <= res_type_q;
					out_data_q.from_queue      <= res_from_q;
					out_data_q.immediate_count <= 6'(imm_cnt);
					out_data_q.standard_count  <= 6'(std_cnt);
					out_data_q.outstanding     <= 16'(pending_q);
					out_data_q.all_done        <= (imm_cnt == '0) && (std_cnt == '0) &&
						(pending_q == '0);
				end
			end
			default: begin
				hold_q <= hold_q;
			end
		endcase
	end

`include "dual_priority_job_queue_macros.svh"

	`DPJQ_ASSERT_IMP(a_imm_ptr_range, 1'b1, (imm_head_q < imm_cap_q) && (imm_tail_q < imm_cap_q), "immediate pointer beyond capacity")
	`DPJQ_ASSERT_IMP(a_std_ptr_range, 1'b1, (std_head_q < std_cap_q) && (std_tail_q < std_cap_q), "standard pointer beyond capacity")
	`DPJQ_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction accepted while busy")
	`DPJQ_ASSERT_IMP(a_all_done_match, out_valid_q, out_data_q.all_done == ((out_data_q.immediate_count == 6'd0) && (out_data_q.standard_count == 6'd0) && (out_data_q.outstanding == 16'd0)), "all_done disagrees with counts")

endmodule
